>>> hw/rtl/table_dfa_acceptor_macros.svh
// Assertion helpers for the DFA acceptor. Both sample on clk and are
// quiet while rst_n is low.
`ifndef TABLE_DFA_ACCEPTOR_MACROS_SVH
`define TABLE_DFA_ACCEPTOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TDFA_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdfa check failed");
// next-cycle implication
`define TDFA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdfa check failed");
`else
`define TDFA_ASSERT_NOW(name, ante, cons)
`define TDFA_ASSERT_NEXT(name, ante, cons)
`endif
`endif

>>> hw/rtl/tdfa_pkg.sv
package tdfa_pkg;

    localparam int MAX_STATES_DEF  = 16;
    localparam int MAX_SYMBOLS_DEF = 8;

    localparam int MODE_W  = 2;
    localparam int STATE_W = 4;
    localparam int SLOT_W  = 3;
    localparam int CHAR_W  = 8;
    localparam int NSYM_W  = 4;
    localparam int MASK_W  = 16;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 16;

    // slots a 3-bit slot field can reach
    localparam int ALPHA_SLOTS = 2 ** SLOT_W;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [MODE_W-1:0] MODE_ALPHA = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRANS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHAR  = 2'd2;

    localparam logic [CIDX_W-1:0] REG_START = 2'd0;
    localparam logic [CIDX_W-1:0] REG_NSYM  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_FMASK = 2'd2;

    localparam logic [NSYM_W-1:0] NSYM_RESET = 4'd8;

    // VERDICT_ACCEPT doubles as "no reject latched"
    typedef enum logic [1:0] {
        VERDICT_ACCEPT    = 2'd0,
        VERDICT_NONFINAL  = 2'd1,
        VERDICT_BAD_CHAR  = 2'd2,
        VERDICT_BAD_STATE = 2'd3
    } verdict_t;

    typedef struct packed {
        logic                known;
        logic [STATE_W-1:0]  target;
    } tdfa_entry_t;

    // classified word passed from front to back
    typedef struct packed {
        logic                is_char;
        logic [STATE_W-1:0]  row;
        logic [SLOT_W-1:0]   slot;
        logic [STATE_W-1:0]  target;
        logic                known;
        logic                last;
        logic                hit;
        logic [SLOT_W-1:0]   col;
    } tdfa_op_t;

endpackage

>>> hw/rtl/tdfa_front.sv
module tdfa_front
    import tdfa_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
)
(
    input  logic                clk,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [MODE_W-1:0]   mode,
    input  logic [STATE_W-1:0]  row_state,
    input  logic [SLOT_W-1:0]   symbol_slot,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [STATE_W-1:0]  target_state,
    input  logic                target_known,
    input  logic                last_char,
    input  logic [NSYM_W-1:0]   num_symbols,
    input  logic                q_full,
    output logic                q_push,
    output tdfa_op_t            q_op
);

    localparam int ALPHA_DEPTH = (MAX_SYMBOLS < ALPHA_SLOTS) ? MAX_SYMBOLS : ALPHA_SLOTS;

    logic [CHAR_W-1:0] alpha_reg [ALPHA_DEPTH];
    logic              accept;
    logic              hit;
    logic [SLOT_W-1:0] col;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;
    assign q_push     = accept && (mode == MODE_TRANS || mode == MODE_CHAR);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ALPHA_DEPTH; i++)
        begin
            if (accept && mode == MODE_ALPHA && symbol_slot == SLOT_W'(i))
            begin
                alpha_reg[i] <= char_code;
            end
        end
    end

    // lowest matching slot wins: scan downward so the last hit sticks
    always_comb
    begin
        hit = 1'b0;
        col = '0;
        for (int i = ALPHA_DEPTH - 1; i >= 0; i--)
        begin
            if (alpha_reg[i] == char_code && NSYM_W'(i) < num_symbols)
            begin
                hit = 1'b1;
                col = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        q_op.is_char = (mode == MODE_CHAR);
        q_op.row     = row_state;
        q_op.slot    = symbol_slot;
        q_op.target  = target_state;
        q_op.known   = target_known;
        q_op.last    = last_char;
        q_op.hit     = hit;
        q_op.col     = col;
    end

endmodule

>>> hw/rtl/tdfa_queue.sv
module tdfa_queue
    import tdfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tdfa_op_t  push_op,
    input  logic      pop,
    output logic      full,
    output logic      head_valid,
    output tdfa_op_t  head_op
);

    tdfa_op_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

>>> hw/rtl/tdfa_back.sv
`include "table_dfa_acceptor_macros.svh"

module tdfa_back
    import tdfa_pkg::*;
#(
    parameter int MAX_STATES  = MAX_STATES_DEF,
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  tdfa_op_t            q_op,
    output logic                q_pop,
    input  logic [STATE_W-1:0]  start_state,
    input  logic [MASK_W-1:0]   final_mask,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [1:0]          verdict,
    output logic [STATE_W-1:0]  end_state
);

    localparam int TDEPTH = MAX_STATES * MAX_SYMBOLS;
    localparam int TA_W   = $clog2(TDEPTH);

    tdfa_entry_t        tmem [TDEPTH];
    tdfa_entry_t        rdata_reg;

    // lookup stage: one character whose table read is in flight
    logic               v2_reg;
    logic               read2_reg;
    logic               last2_reg;
    logic [STATE_W-1:0] state2_reg;
    verdict_t           rej2_reg;

    // string context left by the last resolved character
    logic               ctx_in_reg;
    logic [STATE_W-1:0] ctx_state_reg;
    verdict_t           ctx_rej_reg;

    logic               result_valid_reg;
    verdict_t           verdict_reg;
    logic [STATE_W-1:0] end_state_reg;

    logic               entry_bad;
    logic [STATE_W-1:0] st_res;
    verdict_t           rej_res;
    logic               ctx_in;
    logic [STATE_W-1:0] ctx_state;
    verdict_t           ctx_rej;
    logic [STATE_W-1:0] s_in;
    verdict_t           r_in;
    verdict_t           rej_out;
    logic               adv;
    logic               char_go;
    logic               read_go;
    logic               wr_go;
    logic               res_load;
    logic [TA_W-1:0]    raddr;
    logic [TA_W-1:0]    waddr;

    // resolve the in-flight lookup
    always_comb
    begin
        entry_bad = !rdata_reg.known || (32'(rdata_reg.target) >= MAX_STATES);
        st_res    = state2_reg;
        rej_res   = rej2_reg;
        if (read2_reg)
        begin
            if (entry_bad)
            begin
                rej_res = VERDICT_BAD_STATE;
            end
            else
            begin
                st_res = rdata_reg.target;
            end
        end
    end

    // forward the resolved state: a character can issue each unstalled cycle
    always_comb
    begin
        ctx_in    = v2_reg ? !last2_reg : ctx_in_reg;
        ctx_state = v2_reg ? st_res : ctx_state_reg;
        ctx_rej   = v2_reg ? rej_res : ctx_rej_reg;
        s_in      = ctx_in ? ctx_state : start_state;
        r_in      = ctx_in ? ctx_rej : VERDICT_ACCEPT;
    end

    assign adv     = !(v2_reg && last2_reg && result_valid_reg && result_stall);
    assign q_pop   = q_valid && adv;
    assign char_go = q_pop && q_op.is_char;

    always_comb
    begin
        rej_out = r_in;
        read_go = 1'b0;
        if (r_in == VERDICT_ACCEPT)
        begin
            priority if (32'(s_in) >= MAX_STATES)
            begin
                rej_out = VERDICT_BAD_STATE;
            end
            else if (!q_op.hit)
            begin
                rej_out = VERDICT_BAD_CHAR;
            end
            else
            begin
                read_go = char_go;
            end
        end
    end

    assign raddr = TA_W'(s_in) * TA_W'(MAX_SYMBOLS) + TA_W'(q_op.col);
    assign waddr = TA_W'(q_op.row) * TA_W'(MAX_SYMBOLS) + TA_W'(q_op.slot);
    assign wr_go = q_pop && !q_op.is_char
                   && (32'(q_op.row) < MAX_STATES) && (32'(q_op.slot) < MAX_SYMBOLS);

    always_ff @(posedge clk)
    begin
        if (wr_go)
        begin
            tmem[waddr] <= {q_op.known, q_op.target};
        end
        if (read_go)
        begin
            rdata_reg <= tmem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= char_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_go)
        begin
            read2_reg  <= read_go;
            last2_reg  <= q_op.last;
            state2_reg <= s_in;
            rej2_reg   <= rej_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_in_reg    <= 1'b0;
            ctx_state_reg <= '0;
            ctx_rej_reg   <= VERDICT_ACCEPT;
        end
        else if (adv && v2_reg)
        begin
            ctx_in_reg    <= !last2_reg;
            ctx_state_reg <= st_res;
            ctx_rej_reg   <= rej_res;
        end
    end

    assign res_load = adv && v2_reg && last2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            end_state_reg <= st_res;
            if (rej_res != VERDICT_ACCEPT)
            begin
                verdict_reg <= rej_res;
            end
            else
            begin
                verdict_reg <= final_mask[st_res] ? VERDICT_ACCEPT : VERDICT_NONFINAL;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign verdict      = verdict_reg;
    assign end_state    = end_state_reg;

    // a lookup is only issued for a string with no reject latched
    `TDFA_ASSERT_NOW(a_read_clean, v2_reg && read2_reg, rej2_reg == VERDICT_ACCEPT)
    // nothing leaves the queue while a finished string waits on a full output
    `TDFA_ASSERT_NOW(a_hold_pop, v2_reg && last2_reg && result_valid_reg && result_stall, !q_pop)
    // a held lookup stage keeps its word
    `TDFA_ASSERT_NEXT(a_hold_s2, v2_reg && !adv, v2_reg && $stable(state2_reg))

endmodule

>>> hw/rtl/table_dfa_acceptor.sv
// Table-driven DFA acceptor. Takes one word per clock on the item channel
// unless stalled: alphabet writes, transition writes and characters all
// sustain one per cycle, bounded by the single read port of the transition
// table, whose registered output feeds the next character's lookup address.
// The front matches a character against the alphabet slots when it is
// accepted; a four-entry queue decouples it from the back, which walks the
// table. With the queue empty and the output free, a result is valid once
// a string's last character has passed the queue, lookup stage and result
// register, then the next string starts from start_state. The stores need
// no clearing pass after reset; reading a table entry or alphabet slot that
// was never written gives an unspecified verdict. Configuration is always
// ready and should be written only while the block is quiet.
module table_dfa_acceptor
    import tdfa_pkg::*;
#(
    parameter int MAX_STATES  = MAX_STATES_DEF,
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [MODE_W-1:0]   mode,
    input  logic [STATE_W-1:0]  row_state,
    input  logic [SLOT_W-1:0]   symbol_slot,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [STATE_W-1:0]  target_state,
    input  logic                target_known,
    input  logic                last_char,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [1:0]          verdict,
    output logic [STATE_W-1:0]  end_state,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CDATA_W-1:0]  cfg_data
);

    logic [STATE_W-1:0] start_state_reg;
    logic [NSYM_W-1:0]  num_symbols_reg;
    logic [MASK_W-1:0]  final_mask_reg;

    logic     q_full;
    logic     q_push;
    tdfa_op_t q_in_op;
    logic     q_pop;
    logic     q_head_valid;
    tdfa_op_t q_head_op;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg <= '0;
            num_symbols_reg <= NSYM_RESET;
            final_mask_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_START: start_state_reg <= cfg_data[STATE_W-1:0];
                REG_NSYM:  num_symbols_reg <= cfg_data[NSYM_W-1:0];
                REG_FMASK: final_mask_reg  <= cfg_data[MASK_W-1:0];
                default:   ;
            endcase
        end
    end

    tdfa_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .clk          (clk),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .row_state    (row_state),
        .symbol_slot  (symbol_slot),
        .char_code    (char_code),
        .target_state (target_state),
        .target_known (target_known),
        .last_char    (last_char),
        .num_symbols  (num_symbols_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_op         (q_in_op)
    );

    tdfa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (q_in_op),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_op    (q_head_op)
    );

    tdfa_back #(
        .MAX_STATES  (MAX_STATES),
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_head_valid),
        .q_op         (q_head_op),
        .q_pop        (q_pop),
        .start_state  (start_state_reg),
        .final_mask   (final_mask_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .verdict      (verdict),
        .end_state    (end_state)
    );

endmodule

>>> verif/testbench.sv
module testbench;
    import tdfa_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam logic [CIDX_W-1:0] REG_SPARE = 2'd3;
    localparam int PHASES      = 11;
    localparam int PHASE_WORDS = 100;

    typedef struct packed {
        logic [MODE_W-1:0]  op;
        logic [STATE_W-1:0] row;
        logic [SLOT_W-1:0]  slot;
        logic [CHAR_W-1:0]  ch;
        logic [STATE_W-1:0] tgt;
        logic               known;
        logic               last;
    } word_t;

    typedef struct packed {
        verdict_t           verdict;
        logic [STATE_W-1:0] end_state;
    } outcome_t;

    typedef struct packed {
        word_t    w;
        bit       typed;
        outcome_t res;
    } vector_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_stall;
    logic [MODE_W-1:0]   mode = '0;
    logic [STATE_W-1:0]  row_state = '0;
    logic [SLOT_W-1:0]   symbol_slot = '0;
    logic [CHAR_W-1:0]   char_code = '0;
    logic [STATE_W-1:0]  target_state = '0;
    logic                target_known = 1'b0;
    logic                last_char = 1'b0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [1:0]          verdict;
    logic [STATE_W-1:0]  end_state;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index = '0;
    logic [CDATA_W-1:0]  cfg_data = '0;

    // predictor copy of configuration and automaton state
    logic [STATE_W-1:0]  cfg_start = '0;
    logic [NSYM_W-1:0]   cfg_nsym = NSYM_RESET;
    logic [MASK_W-1:0]   cfg_fmask = '0;
    logic [STATE_W-1:0]  dfa_cur = '0;
    verdict_t            dfa_reject = VERDICT_ACCEPT;
    bit                  dfa_in_string = 1'b0;
    logic [CHAR_W-1:0]   alpha_mem [ALPHA_SLOTS];
    tdfa_entry_t         trans_mem [MAX_STATES_DEF * ALPHA_SLOTS];
    bit                  trans_loaded [MAX_STATES_DEF * ALPHA_SLOTS];

    outcome_t            verdict_q [$];
    int                  mismatches = 0;
    int                  words_sent = 0;
    int                  gap_odds = 4;
    int                  stall_left = 0;

    // alphabet is written in full first, so every slot is defined before any character
    vector_t directed_rows [25] = '{
        '{'{MODE_ALPHA, 4'd0,  3'd0, 8'h61, 4'd0,  1'b0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_ALPHA, 4'd0,  3'd1, 8'h00, 4'd0,  1'b0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_ALPHA, 4'd0,  3'd2, 8'hff, 4'd0,  1'b0, 1'b1}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_ALPHA, 4'd0,  3'd3, 8'h61, 4'd0,  1'b0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_ALPHA, 4'd0,  3'd4, 8'h10, 4'd0,  1'b0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_ALPHA, 4'd0,  3'd5, 8'h20, 4'd0,  1'b0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_ALPHA, 4'd0,  3'd6, 8'h30, 4'd0,  1'b0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_ALPHA, 4'd0,  3'd7, 8'h40, 4'd0,  1'b0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_TRANS, 4'd0,  3'd0, 8'h00, 4'd1,  1'b1, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_TRANS, 4'd1,  3'd0, 8'h00, 4'd15, 1'b1, 1'b1}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_TRANS, 4'd15, 3'd2, 8'h00, 4'd0,  1'b1, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_TRANS, 4'd0,  3'd1, 8'h00, 4'd5,  1'b0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_TRANS, 4'd15, 3'd7, 8'h00, 4'd15, 1'b1, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        // single chars: non-final, unknown char, unknown target
        '{'{MODE_CHAR,  4'd0,  3'd0, 8'h61, 4'd0,  1'b0, 1'b1}, 1'b1, '{VERDICT_NONFINAL, 4'd1}},
        '{'{MODE_CHAR,  4'd0,  3'd0, 8'h77, 4'd0,  1'b0, 1'b1}, 1'b1, '{VERDICT_BAD_CHAR, 4'd0}},
        '{'{MODE_CHAR,  4'd0,  3'd0, 8'h00, 4'd0,  1'b0, 1'b1}, 1'b1, '{VERDICT_BAD_STATE, 4'd0}},
        '{'{MODE_CHAR,  4'd0,  3'd0, 8'h61, 4'd0,  1'b0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_CHAR,  4'd0,  3'd0, 8'h61, 4'd0,  1'b0, 1'b1}, 1'b1, '{VERDICT_NONFINAL, 4'd15}},
        '{'{MODE_CHAR,  4'd0,  3'd0, 8'h61, 4'd0,  1'b0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_CHAR,  4'd0,  3'd0, 8'h61, 4'd0,  1'b0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_CHAR,  4'd0,  3'd0, 8'hff, 4'd0,  1'b0, 1'b1}, 1'b1, '{VERDICT_NONFINAL, 4'd0}},
        // reject latches at state 1, the trailing char is ignored
        '{'{MODE_CHAR,  4'd0,  3'd0, 8'h61, 4'd0,  1'b0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_CHAR,  4'd0,  3'd0, 8'h77, 4'd0,  1'b0, 1'b0}, 1'b0, '{VERDICT_ACCEPT, 4'd0}},
        '{'{MODE_CHAR,  4'd0,  3'd0, 8'h61, 4'd0,  1'b0, 1'b1}, 1'b1, '{VERDICT_BAD_CHAR, 4'd1}},
        '{'{MODE_NONE,  4'd0,  3'd0, 8'h61, 4'd0,  1'b0, 1'b1}, 1'b0, '{VERDICT_ACCEPT, 4'd0}}
    };

    table_dfa_acceptor u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .row_state    (row_state),
        .symbol_slot  (symbol_slot),
        .char_code    (char_code),
        .target_state (target_state),
        .target_known (target_known),
        .last_char    (last_char),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .verdict      (verdict),
        .end_state    (end_state),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // lowest slot holding the character, -1 if none among the slots in use
    function automatic int match_slot(input logic [CHAR_W-1:0] ch);
        int used;
        used = (cfg_nsym > ALPHA_SLOTS) ? ALPHA_SLOTS : int'(cfg_nsym);
        for (int i = 0; i < used; i++)
        begin
            if (alpha_mem[i] == ch)
                return i;
        end
        return -1;
    endfunction

    function automatic bit dfa_step(input word_t w, output outcome_t res);
        int          col;
        tdfa_entry_t ent;
        bit          done;
        done = 1'b0;
        res = '0;
        case (w.op)
            MODE_ALPHA: alpha_mem[w.slot] = w.ch;
            MODE_TRANS:
            begin
                trans_mem[{w.row, w.slot}] = '{known: w.known, target: w.tgt};
                trans_loaded[{w.row, w.slot}] = 1'b1;
            end
            MODE_CHAR:
            begin
                if (!dfa_in_string)
                begin
                    dfa_cur = cfg_start;
                    dfa_reject = VERDICT_ACCEPT;
                    dfa_in_string = 1'b1;
                end
                if (dfa_reject == VERDICT_ACCEPT)
                begin
                    col = match_slot(w.ch);
                    if (col < 0)
                        dfa_reject = VERDICT_BAD_CHAR;
                    else
                    begin
                        ent = trans_mem[{dfa_cur, col[SLOT_W-1:0]}];
                        if (!ent.known)
                            dfa_reject = VERDICT_BAD_STATE;
                        else
                            dfa_cur = ent.target;
                    end
                end
                if (w.last)
                begin
                    if (dfa_reject != VERDICT_ACCEPT)
                        res.verdict = dfa_reject;
                    else
                        res.verdict = cfg_fmask[dfa_cur] ? VERDICT_ACCEPT : VERDICT_NONFINAL;
                    res.end_state = dfa_cur;
                    dfa_cur = cfg_start;
                    dfa_reject = VERDICT_ACCEPT;
                    dfa_in_string = 1'b0;
                    done = 1'b1;
                end
            end
            default: ;
        endcase
        return done;
    endfunction

    function automatic word_t rand_word();
        word_t       w;
        logic [31:0] bits;
        bits = $urandom;
        w.op    = bits[1:0];
        w.row   = bits[5:2];
        w.slot  = bits[8:6];
        w.ch    = bits[16:9];
        w.tgt   = bits[20:17];
        w.known = bits[21];
        w.last  = bits[22];
        return w;
    endfunction

    task automatic send_word(input word_t w, input bit typed, input outcome_t typed_res);
        outcome_t res;
        bit       hit;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item_valid   <= 1'b1;
        mode         <= w.op;
        row_state    <= w.row;
        symbol_slot  <= w.slot;
        char_code    <= w.ch;
        target_state <= w.tgt;
        target_known <= w.known;
        last_char    <= w.last;
        @(posedge clk);
        while (item_stall !== 1'b0)
            @(posedge clk);
        hit = dfa_step(w, res);
        if (hit)
            verdict_q.push_back(typed ? typed_res : res);
        words_sent++;
    endtask

    // a table entry the character would read is loaded first, never read unwritten
    task automatic feed_char(input logic [CHAR_W-1:0] ch, input logic last);
        word_t              w;
        logic [STATE_W-1:0] st;
        int                 col;
        st = dfa_in_string ? dfa_cur : cfg_start;
        if (!dfa_in_string || dfa_reject == VERDICT_ACCEPT)
        begin
            col = match_slot(ch);
            if (col >= 0 && !trans_loaded[{st, col[SLOT_W-1:0]}])
            begin
                w = rand_word();
                w.op = MODE_TRANS;
                w.row = st;
                w.slot = col[SLOT_W-1:0];
                w.known = ($urandom_range(0, 9) != 0);
                send_word(w, 1'b0, '0);
            end
        end
        w = rand_word();
        w.op = MODE_CHAR;
        w.ch = ch;
        w.last = last;
        send_word(w, 1'b0, '0);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        case (idx)
            REG_START: cfg_start = data[STATE_W-1:0];
            REG_NSYM:  cfg_nsym  = data[NSYM_W-1:0];
            REG_FMASK: cfg_fmask = data;
            default: ;
        endcase
    endtask

    // drain results, then give words with no result time to leave the pipe
    task automatic settle();
        item_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            result_stall <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : check_results
        outcome_t exp;
        if (rst_n && result_valid === 1'b1 && result_stall == 1'b0)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result word with nothing expected: verdict %0d end_state %0d",
                       verdict, end_state);
                mismatches++;
            end
            else
            begin
                exp = verdict_q.pop_front();
                if (verdict !== exp.verdict)
                begin
                    $error("verdict: expected %0d, actual %0d", exp.verdict, verdict);
                    mismatches++;
                end
                if (end_state !== exp.end_state)
                begin
                    $error("end_state: expected %0d, actual %0d", exp.end_state, end_state);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int                 phase;
        int                 len;
        int                 used;
        int                 k;
        logic [STATE_W-1:0] st_v;
        logic [NSYM_W-1:0]  ns_v;
        logic [MASK_W-1:0]  fm_v;
        logic [CHAR_W-1:0]  ch;
        logic [31:0]        pad;
        word_t              w;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].res);

        for (phase = 0; phase < PHASES; phase++)
        begin
            settle();
            // last phase runs with no idling on either side
            if (phase == PHASES - 1)
                gap_odds = 0;
            else if ($urandom_range(0, 3) == 0)
                gap_odds = 0;
            else
                gap_odds = $urandom_range(2, 8);

            pad = $urandom;
            case (phase)
                0: begin st_v = 4'd15; ns_v = 4'd1;  fm_v = 16'hffff; end
                1: begin st_v = 4'd0;  ns_v = 4'd8;  fm_v = 16'h0000; end
                2: begin st_v = 4'($urandom_range(0, 15)); ns_v = 4'd0;  fm_v = pad[15:0]; end
                3: begin st_v = 4'($urandom_range(0, 15)); ns_v = 4'd15; fm_v = pad[31:16]; end
                default:
                begin
                    st_v = 4'($urandom_range(0, 15));
                    ns_v = 4'($urandom_range(1, 8));
                    fm_v = pad[15:0];
                end
            endcase
            // upper data bits are don't-care for the narrow registers
            write_reg(REG_START, {pad[27:16], st_v});
            write_reg(REG_NSYM, {pad[11:0], ns_v});
            write_reg(REG_FMASK, fm_v);
            if (phase % 3 == 0)
                write_reg(REG_SPARE, pad[31:16]);
            cfg_valid <= 1'b0;

            // fresh alphabet, duplicates now and then
            for (int s = 0; s < ALPHA_SLOTS; s++)
            begin
                w = rand_word();
                w.op = MODE_ALPHA;
                w.slot = 3'(s);
                if ($urandom_range(0, 3) == 0)
                    w.ch = 8'($urandom_range(0, 3));
                send_word(w, 1'b0, '0);
            end
            repeat (8)
            begin
                w = rand_word();
                w.op = MODE_TRANS;
                w.known = ($urandom_range(0, 7) != 0);
                send_word(w, 1'b0, '0);
            end

            while (words_sent < 25 + PHASE_WORDS * (phase + 1))
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        w = rand_word();
                        case ($urandom_range(0, 2))
                            0: w.op = MODE_NONE;
                            1: w.op = MODE_TRANS;
                            default: w.op = MODE_ALPHA;
                        endcase
                        send_word(w, 1'b0, '0);
                    end
                    used = (cfg_nsym > ALPHA_SLOTS) ? ALPHA_SLOTS : int'(cfg_nsym);
                    if (used != 0 && $urandom_range(0, 6) != 0)
                        ch = alpha_mem[$urandom_range(0, used - 1)];
                    else
                        ch = 8'($urandom_range(0, 255));
                    feed_char(ch, (i == len - 1));
                end
            end
        end

        item_valid <= 1'b0;
        for (k = 0; k < 5000 && verdict_q.size() != 0; k++)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (verdict_q.size() != 0)
        begin
            $error("%0d expected result words never arrived", verdict_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #3200000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/tdfa_pkg.sv
hw/rtl/tdfa_front.sv
hw/rtl/tdfa_queue.sv
hw/rtl/tdfa_back.sv
hw/rtl/table_dfa_acceptor.sv
verif/testbench.sv
